// ----- src/efa_pkg.sv -----
// Package for the event fragment assembler.
// Holds table sizes, field widths, status codes and register indexes.
// No dependencies.
package efa_pkg;

	localparam int SLOTS     = 256;
	localparam int SOURCES   = 32;
	localparam int IDX_W     = $clog2(SLOTS);
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int TRG_W     = 32;
	localparam int SRC_W     = 5;
	localparam int MASK_W    = 32;
	localparam int LIMIT_W   = 8;
	localparam int STATUS_W  = 3;
	localparam int RCOUNT_W  = 9;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 32;

	localparam logic [MASK_W-1:0] SRC_MASK = MASK_W'({SOURCES{1'b1}});
	localparam logic [MASK_W-1:0] MASK_RESET  = '1;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);
	localparam logic [TRG_W-1:0] MIN_READY_RESET = '1;

	localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_COMPLETED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DISABLED  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_READY_LIMIT   = 1'b1;

endpackage

// ----- src/efa_frag_if.sv -----
// Fragment request channel of the event fragment assembler.
// Depends on efa_pkg for field widths.
interface efa_frag_if;
	logic                        valid;
	logic                        ready;
	logic [efa_pkg::TRG_W-1:0]   trigger_number;
	logic [efa_pkg::SRC_W-1:0]   source_id;

	modport source (output valid, trigger_number, source_id, input ready);
	modport sink (input valid, trigger_number, source_id, output ready);
endinterface

// ----- src/efa_result_if.sv -----
// Result channel of the event fragment assembler.
// Depends on efa_pkg for field widths.
interface efa_result_if;
	logic                           valid;
	logic                           ready;
	logic [efa_pkg::STATUS_W-1:0]   fragment_status;
	logic                           missed_flag;
	logic [efa_pkg::TRG_W-1:0]      missed_trigger;
	logic                           skip_flag;
	logic [efa_pkg::TRG_W-1:0]      release_first;
	logic [efa_pkg::RCOUNT_W-1:0]   release_count;

	modport source (output valid, fragment_status, missed_flag, missed_trigger, skip_flag,
		release_first, release_count, input ready);
	modport sink (input valid, fragment_status, missed_flag, missed_trigger, skip_flag,
		release_first, release_count, output ready);
endinterface

// ----- src/efa_cfg_if.sv -----
// Configuration write channel of the event fragment assembler.
// Depends on efa_pkg for index and data widths.
interface efa_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [efa_pkg::CFG_IDX_W-1:0]   index;
	logic [efa_pkg::CFG_DAT_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/efa_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module efa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/event_fragment_assembler.sv -----
// Event fragment assembler: slot triggers and received masks in two RAMs, a valid bit per slot.
// A fragment is classified in S_READ and its result registered from S_DONE; a release
// walk reads, then checks, each slot (S_WALK_RD, S_WALK_CHK), a skip clears slots in S_SKIP.
// A new fragment is taken only in S_IDLE, after the read-modify-write of the slot is done;
// a result held at the output stalls the next fragment. Reset: arst_n clears all control state
// and the per-slot valid bits, so every slot reads as trigger 0 with no sources received.
module event_fragment_assembler (
	input  logic            clk,
	input  logic            arst_n,
	efa_frag_if.sink        frag,
	efa_result_if.source    result,
	efa_cfg_if.sink         cfg
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SKIP,
		S_WALK_RD,
		S_WALK_CHK,
		S_DONE
	} state_t;

	localparam int IW = efa_pkg::IDX_W;
	localparam int TW = efa_pkg::TRG_W;
	localparam int MW = efa_pkg::MASK_W;

	state_t                          state_q;
	logic [TW-1:0]                   trg_q;
	logic [efa_pkg::SRC_W-1:0]       src_q;
	logic [TW-1:0]                   nts_q;
	logic [efa_pkg::LIMIT_W-1:0]     rc_q;
	logic [TW-1:0]                   minr_q;
	logic [MW-1:0]                   mask_q;
	logic [efa_pkg::LIMIT_W-1:0]     limit_q;
	logic [efa_pkg::SLOTS-1:0]       tvalid_q;
	logic [IW-1:0]                   ptr_q;
	logic [IW-1:0]                   walk_n_q;
	logic [efa_pkg::CNT_W-1:0]       count_q;
	logic [TW-1:0]                   first_q;
	logic [efa_pkg::STATUS_W-1:0]    status_q;
	logic                            missed_q;
	logic [TW-1:0]                   missed_trg_q;
	logic                            skip_q;

	logic                            out_valid_q;
	logic [efa_pkg::STATUS_W-1:0]    out_status_q;
	logic                            out_missed_q;
	logic [TW-1:0]                   out_missed_trg_q;
	logic                            out_skip_q;
	logic [TW-1:0]                   out_first_q;
	logic [efa_pkg::RCOUNT_W-1:0]    out_count_q;

	logic [IW-1:0]                   idx;
	logic [IW-1:0]                   walk_idx;
	logic [IW-1:0]                   raddr;
	logic [TW-1:0]                   trig_rdata;
	logic [MW-1:0]                   recv_rdata;
	logic                            trig_we;
	logic                            recv_we;
	logic [IW-1:0]                   recv_waddr;
	logic [MW-1:0]                   recv_wdata;
	logic [MW-1:0]                   en;
	logic [TW-1:0]                   slot_t;
	logic [MW-1:0]                   slot_r;
	logic [MW-1:0]                   src_bit;
	logic [MW-1:0]                   new_recv;
	logic [efa_pkg::STATUS_W-1:0]    cls_status;
	logic                            cls_modify;
	logic                            cls_done;
	logic                            cls_missed;
	logic [TW-1:0]                   walk_t;
	logic [MW-1:0]                   walk_r;
	logic                            walk_hit;
	logic [15:0]                     count_ext;
	logic                            accept_in;
	logic                            out_load;

	assign idx       = trg_q[IW-1:0];
	assign walk_idx  = nts_q[IW-1:0];
	assign en        = mask_q & efa_pkg::SRC_MASK;
	assign accept_in = frag.valid && frag.ready;
	assign frag.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || result.ready);

	assign raddr = (state_q == S_IDLE) ? frag.trigger_number[IW-1:0] : walk_idx;

	efa_ram #(
		.WIDTH(TW),
		.DEPTH(efa_pkg::SLOTS)
	) u_trig_ram (
		.clk   (clk),
		.we    (trig_we),
		.waddr (idx),
		.wdata (trg_q),
		.raddr (raddr),
		.rdata (trig_rdata)
	);

	efa_ram #(
		.WIDTH(MW),
		.DEPTH(efa_pkg::SLOTS)
	) u_recv_ram (
		.clk   (clk),
		.we    (recv_we),
		.waddr (recv_waddr),
		.wdata (recv_wdata),
		.raddr (raddr),
		.rdata (recv_rdata)
	);

	always_comb begin
		slot_t     = tvalid_q[idx] ? trig_rdata : '0;
		slot_r     = tvalid_q[idx] ? recv_rdata : '0;
		src_bit    = MW'(1) << src_q;
		new_recv   = slot_r;
		cls_status = efa_pkg::ST_ACCEPTED;
		cls_modify = 1'b0;
		cls_missed = 1'b0;
		priority if ((6'(src_q) >= 6'(efa_pkg::SOURCES)) || !en[src_q]) begin
			cls_status = efa_pkg::ST_DISABLED;
		end else if (trg_q == slot_t) begin
			if ((slot_r & src_bit) != '0) begin
				cls_status = efa_pkg::ST_DUPLICATE;
			end else begin
				new_recv   = slot_r | src_bit;
				cls_modify = 1'b1;
			end
		end else if (trg_q > slot_t) begin
			cls_missed = (slot_r != '0);
			new_recv   = src_bit;
			cls_modify = 1'b1;
		end else begin
			cls_status = efa_pkg::ST_EXPIRED;
		end
		cls_done = cls_modify && ((new_recv & en) == en);
		trig_we  = (state_q == S_READ) && cls_modify;
	end

	always_comb begin
		walk_t   = tvalid_q[walk_idx] ? trig_rdata : '0;
		walk_r   = tvalid_q[walk_idx] ? recv_rdata : '0;
		walk_hit = ((walk_r & en) == en) && (walk_t == nts_q);
	end

	// Received masks are cleared in the RAM by the skip and by the release walk.
	always_comb begin
		recv_we    = 1'b0;
		recv_waddr = idx;
		recv_wdata = '0;
		if (state_q == S_READ) begin
			recv_we    = cls_modify;
			recv_wdata = new_recv;
		end else if (state_q == S_SKIP) begin
			recv_we    = (ptr_q != minr_q[IW-1:0]);
			recv_waddr = ptr_q;
		end else if (state_q == S_WALK_CHK) begin
			recv_we    = walk_hit;
			recv_waddr = walk_idx;
		end
	end

	assign count_ext = 16'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			trg_q            <= '0;
			src_q            <= '0;
			nts_q            <= '0;
			rc_q             <= '0;
			minr_q           <= efa_pkg::MIN_READY_RESET;
			mask_q           <= efa_pkg::MASK_RESET;
			limit_q          <= efa_pkg::LIMIT_RESET;
			tvalid_q         <= '0;
			ptr_q            <= '0;
			walk_n_q         <= '0;
			count_q          <= '0;
			first_q          <= '0;
			status_q         <= efa_pkg::ST_ACCEPTED;
			missed_q         <= 1'b0;
			missed_trg_q     <= '0;
			skip_q           <= 1'b0;
			out_valid_q      <= 1'b0;
			out_status_q     <= efa_pkg::ST_ACCEPTED;
			out_missed_q     <= 1'b0;
			out_missed_trg_q <= '0;
			out_skip_q       <= 1'b0;
			out_first_q      <= '0;
			out_count_q      <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					efa_pkg::REG_SOURCE_ENABLE: mask_q  <= cfg.data;
					efa_pkg::REG_READY_LIMIT:   limit_q <= cfg.data[efa_pkg::LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept_in) begin
						trg_q   <= frag.trigger_number;
						src_q   <= frag.source_id;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (cls_modify) begin
						tvalid_q[idx] <= 1'b1;
					end
					missed_q     <= cls_missed;
					missed_trg_q <= cls_missed ? slot_t : '0;
					skip_q       <= 1'b0;
					count_q      <= '0;
					first_q      <= '0;
					status_q     <= cls_done ? efa_pkg::ST_COMPLETED : cls_status;
					if (!cls_done) begin
						state_q <= S_DONE;
					end else if (trg_q == nts_q) begin
						rc_q     <= '0;
						minr_q   <= efa_pkg::MIN_READY_RESET;
						first_q  <= nts_q;
						walk_n_q <= '0;
						state_q  <= S_WALK_RD;
					end else if (rc_q < limit_q) begin
						if (trg_q < minr_q) begin
							minr_q <= trg_q;
						end
						rc_q    <= rc_q + 1'b1;
						state_q <= S_DONE;
					end else begin
						skip_q  <= 1'b1;
						ptr_q   <= nts_q[IW-1:0];
						state_q <= S_SKIP;
					end
				end
				S_SKIP: begin
					if (ptr_q != minr_q[IW-1:0]) begin
						ptr_q <= ptr_q + 1'b1;
					end else begin
						nts_q    <= minr_q;
						first_q  <= minr_q;
						rc_q     <= '0;
						minr_q   <= efa_pkg::MIN_READY_RESET;
						walk_n_q <= '0;
						state_q  <= S_WALK_RD;
					end
				end
				S_WALK_RD: begin
					state_q <= S_WALK_CHK;
				end
				S_WALK_CHK: begin
					if (walk_hit) begin
						nts_q    <= nts_q + 1'b1;
						count_q  <= count_q + 1'b1;
						walk_n_q <= walk_n_q + 1'b1;
						state_q  <= (walk_n_q == IW'(efa_pkg::SLOTS - 1)) ?
							S_DONE : S_WALK_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						out_status_q     <= status_q;
						out_missed_q     <= missed_q;
						out_missed_trg_q <= missed_trg_q;
						out_skip_q       <= skip_q;
						out_first_q      <= (count_q == '0) ? '0 : first_q;
						out_count_q      <= (count_ext > 16'd511) ? 9'd511 : count_ext[8:0];
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid           = out_valid_q;
	assign result.fragment_status = out_status_q;
	assign result.missed_flag     = out_missed_q;
	assign result.missed_trigger  = out_missed_trg_q;
	assign result.skip_flag       = out_skip_q;
	assign result.release_first   = out_first_q;
	assign result.release_count   = out_count_q;

	// A skip or a release only happens for a fragment that completed its event.
	a_skip_completed: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.skip_flag |-> result.fragment_status == efa_pkg::ST_COMPLETED)
		else $error("skip reported for a fragment that did not complete an event");

	a_release_completed: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.release_count != '0) |->
		result.fragment_status == efa_pkg::ST_COMPLETED)
		else $error("release reported for a fragment that did not complete an event");

	// A slot is only taken over by a fragment that was stored.
	a_missed_stored: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.missed_flag |->
		(result.fragment_status == efa_pkg::ST_ACCEPTED ||
		result.fragment_status == efa_pkg::ST_COMPLETED))
		else $error("missed trigger reported for a fragment that was not stored");

	// Every walk check sees data read for the slot due in the cycle before.
	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK_CHK |-> $past(state_q) == S_WALK_RD && $stable(nts_q))
		else $error("release walk checked a slot without reading it first");

endmodule

// ----- sim/event_fragment_assembler_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for event_fragment_assembler: directed table, then random phases.
// Depends on efa_pkg and the fragment, result and configuration interfaces.
module event_fragment_assembler_tb;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES = 6;

	typedef struct {
		logic [efa_pkg::STATUS_W-1:0] status;
		logic                         missed;
		logic [efa_pkg::TRG_W-1:0]    missed_trg;
		logic                         skip;
		logic [efa_pkg::TRG_W-1:0]    first;
		logic [efa_pkg::RCOUNT_W-1:0] count;
	} frag_result_t;

	typedef enum logic {ROW_FRAG, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t    kind;
		logic [31:0]  value;
		logic [4:0]   sel;
		logic         typed;
		frag_result_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	efa_frag_if   frag_ch ();
	efa_result_if res_ch ();
	efa_cfg_if    cfg_ch ();

	event_fragment_assembler DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.frag   (frag_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// Predicted copy of the slot table, the release pointer and the registers.
	logic [efa_pkg::TRG_W-1:0]   tbl_trigger  [efa_pkg::SLOTS];
	logic [efa_pkg::MASK_W-1:0]  tbl_received [efa_pkg::SLOTS];
	logic [efa_pkg::TRG_W-1:0]   due_trigger;
	logic [efa_pkg::LIMIT_W-1:0] ooo_count;
	logic [efa_pkg::TRG_W-1:0]   lowest_ready;
	logic [efa_pkg::MASK_W-1:0]  src_enable;
	logic [efa_pkg::LIMIT_W-1:0] limit_reg;

	frag_result_t pending_results [$];
	frag_result_t mon_want;
	int err_count;
	int quiet_cycles;
	int cfg_writes;
	int n_by_status [5];
	int n_missed;
	int n_skips;
	int n_released;
	logic frag_calm;
	logic res_calm;

	wire frag_take = frag_ch.valid && frag_ch.ready;
	wire res_take  = res_ch.valid && res_ch.ready;
	wire cfg_take  = cfg_ch.valid && cfg_ch.ready;

	function automatic logic slot_done(input logic [efa_pkg::IDX_W-1:0] idx);
		logic [efa_pkg::MASK_W-1:0] en;
		en = src_enable & efa_pkg::SRC_MASK;
		return (tbl_received[idx] & en) == en;
	endfunction

	function automatic frag_result_t assemble_fragment(input logic [efa_pkg::TRG_W-1:0] trg,
			input logic [efa_pkg::SRC_W-1:0] src);
		frag_result_t res;
		logic [efa_pkg::IDX_W-1:0] idx;
		logic [efa_pkg::IDX_W-1:0] a;
		logic [efa_pkg::IDX_W-1:0] b;
		logic [efa_pkg::MASK_W-1:0] en;
		logic done;
		logic send;
		logic walking;
		int n;
		int cnt;
		res.status = efa_pkg::ST_ACCEPTED;
		res.missed = 1'b0;
		res.missed_trg = '0;
		res.skip = 1'b0;
		res.first = '0;
		res.count = '0;
		idx = trg[efa_pkg::IDX_W-1:0];
		en = src_enable & efa_pkg::SRC_MASK;
		done = 1'b0;
		send = 1'b0;
		cnt = 0;
		if (int'(src) >= efa_pkg::SOURCES || !en[src]) begin
			res.status = efa_pkg::ST_DISABLED;
		end else if (trg == tbl_trigger[idx]) begin
			if (tbl_received[idx][src]) begin
				res.status = efa_pkg::ST_DUPLICATE;
			end else begin
				tbl_received[idx][src] = 1'b1;
				done = slot_done(idx);
			end
		end else if (trg > tbl_trigger[idx]) begin
			if (tbl_received[idx] != '0) begin
				res.missed = 1'b1;
				res.missed_trg = tbl_trigger[idx];
			end
			tbl_trigger[idx] = trg;
			tbl_received[idx] = '0;
			tbl_received[idx][src] = 1'b1;
			done = slot_done(idx);
		end else begin
			res.status = efa_pkg::ST_EXPIRED;
		end
		if (done) begin
			res.status = efa_pkg::ST_COMPLETED;
			if (trg == due_trigger) begin
				send = 1'b1;
			end else if (ooo_count < limit_reg) begin
				if (trg < lowest_ready)
					lowest_ready = trg;
				ooo_count = ooo_count + 1'b1;
			end else begin
				a = due_trigger[efa_pkg::IDX_W-1:0];
				b = lowest_ready[efa_pkg::IDX_W-1:0];
				for (n = 0; n < efa_pkg::SLOTS && a != b; n++) begin
					tbl_received[a] = '0;
					a = a + 1'b1;
				end
				due_trigger = lowest_ready;
				res.skip = 1'b1;
				send = 1'b1;
			end
			if (send) begin
				ooo_count = '0;
				lowest_ready = efa_pkg::MIN_READY_RESET;
				res.first = due_trigger;
				walking = 1'b1;
				for (n = 0; n < efa_pkg::SLOTS && walking; n++) begin
					idx = due_trigger[efa_pkg::IDX_W-1:0];
					if (!slot_done(idx) || tbl_trigger[idx] != due_trigger) begin
						walking = 1'b0;
					end else begin
						tbl_received[idx] = '0;
						due_trigger = due_trigger + 1'b1;
						cnt++;
					end
				end
				if (cnt == 0)
					res.first = '0;
				res.count = efa_pkg::RCOUNT_W'((cnt > 511) ? 511 : cnt);
			end
		end
		return res;
	endfunction

	function automatic stim_row_t frag_row(input logic [31:0] trg, input logic [4:0] src);
		stim_row_t row;
		row.kind = ROW_FRAG;
		row.value = trg;
		row.sel = src;
		row.typed = 1'b0;
		row.want.status = efa_pkg::ST_ACCEPTED;
		row.want.missed = 1'b0;
		row.want.missed_trg = '0;
		row.want.skip = 1'b0;
		row.want.first = '0;
		row.want.count = '0;
		return row;
	endfunction

	function automatic stim_row_t known_row(input logic [31:0] trg, input logic [4:0] src,
			input logic [efa_pkg::STATUS_W-1:0] status, input logic missed,
			input logic [efa_pkg::TRG_W-1:0] missed_trg);
		stim_row_t row;
		row = frag_row(trg, src);
		row.typed = 1'b1;
		row.want.status = status;
		row.want.missed = missed;
		row.want.missed_trg = missed_trg;
		return row;
	endfunction

	function automatic stim_row_t reg_row(input logic [efa_pkg::CFG_IDX_W-1:0] index,
			input logic [31:0] data);
		stim_row_t row;
		row = frag_row(data, 5'(index));
		row.kind = ROW_REG;
		return row;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			err_count++;
		end
	endfunction

	task automatic drive_fragment(input logic [efa_pkg::TRG_W-1:0] trg,
			input logic [efa_pkg::SRC_W-1:0] src);
		int gap;
		if ($urandom_range(0, 31) == 0)
			frag_calm = !frag_calm;
		gap = frag_calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			frag_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frag_ch.valid <= 1'b1;
		frag_ch.trigger_number <= trg;
		frag_ch.source_id <= src;
		do @(posedge clk); while (!frag_ch.ready);
	endtask

	// Registers change only with no request in flight and every result returned.
	task automatic write_reg(input logic [efa_pkg::CFG_IDX_W-1:0] index,
			input logic [efa_pkg::CFG_DAT_W-1:0] data);
		frag_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (index == efa_pkg::REG_SOURCE_ENABLE)
			src_enable = data;
		else if (index == efa_pkg::REG_READY_LIMIT)
			limit_reg = data[efa_pkg::LIMIT_W-1:0];
		cfg_writes++;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		int stall;
		res_calm = 1'b0;
		forever begin
			if ($urandom_range(0, 31) == 0)
				res_calm = !res_calm;
			stall = res_calm ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	always @(posedge clk) begin
		if (res_take) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no request pending, expected none, actual status %0d",
					$time, res_ch.fragment_status);
				err_count++;
			end else begin
				mon_want = pending_results.pop_front();
				check_field("fragment_status", 32'(mon_want.status),
					32'(res_ch.fragment_status));
				check_field("missed_flag", 32'(mon_want.missed), 32'(res_ch.missed_flag));
				check_field("missed_trigger", mon_want.missed_trg, res_ch.missed_trigger);
				check_field("skip_flag", 32'(mon_want.skip), 32'(res_ch.skip_flag));
				check_field("release_first", mon_want.first, res_ch.release_first);
				check_field("release_count", 32'(mon_want.count), 32'(res_ch.release_count));
			end
			if (res_ch.fragment_status <= efa_pkg::ST_DISABLED)
				n_by_status[res_ch.fragment_status]++;
			n_missed += res_ch.missed_flag;
			n_skips += res_ch.skip_flag;
			n_released += res_ch.release_count;
		end
	end

	always @(posedge clk) begin
		if (frag_take || res_take || cfg_take)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		stim_row_t dir_rows [$];
		stim_row_t row;
		frag_result_t got;
		logic [efa_pkg::TRG_W-1:0] trg;
		logic [efa_pkg::SRC_W-1:0] src;
		logic [efa_pkg::TRG_W-1:0] stream_pos;
		logic [efa_pkg::MASK_W-1:0] mask;
		logic [efa_pkg::LIMIT_W-1:0] limit;
		int window;
		int n_items;
		int total_items;
		int i;
		int p;
		int n;
		int r;

		err_count = 0;
		quiet_cycles = 0;
		cfg_writes = 0;
		n_missed = 0;
		n_skips = 0;
		n_released = 0;
		total_items = 0;
		for (i = 0; i < 5; i++)
			n_by_status[i] = 0;
		frag_calm = 1'b0;
		for (i = 0; i < efa_pkg::SLOTS; i++) begin
			tbl_trigger[i] = '0;
			tbl_received[i] = '0;
		end
		due_trigger = '0;
		ooo_count = '0;
		lowest_ready = efa_pkg::MIN_READY_RESET;
		src_enable = efa_pkg::MASK_RESET;
		limit_reg = efa_pkg::LIMIT_RESET;

		arst_n <= 1'b0;
		frag_ch.valid <= 1'b0;
		frag_ch.trigger_number <= '0;
		frag_ch.source_id <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		dir_rows.push_back(known_row(32'h0, 5'd0, efa_pkg::ST_ACCEPTED, 1'b0, 32'h0));
		dir_rows.push_back(known_row(32'h0, 5'd0, efa_pkg::ST_DUPLICATE, 1'b0, 32'h0));
		dir_rows.push_back(known_row(32'hFFFF_FFFF, 5'd31, efa_pkg::ST_ACCEPTED, 1'b0, 32'h0));
		dir_rows.push_back(known_row(32'h100, 5'd5, efa_pkg::ST_ACCEPTED, 1'b1, 32'h0));
		dir_rows.push_back(known_row(32'h0, 5'd3, efa_pkg::ST_EXPIRED, 1'b0, 32'h0));
		dir_rows.push_back(known_row(32'hFF, 5'd31, efa_pkg::ST_EXPIRED, 1'b0, 32'h0));
		dir_rows.push_back(reg_row(efa_pkg::REG_SOURCE_ENABLE, 32'h3));
		dir_rows.push_back(reg_row(efa_pkg::REG_READY_LIMIT, 32'd2));
		dir_rows.push_back(known_row(32'h55, 5'd7, efa_pkg::ST_DISABLED, 1'b0, 32'h0));
		dir_rows.push_back(known_row(32'h1, 5'd31, efa_pkg::ST_DISABLED, 1'b0, 32'h0));
		dir_rows.push_back(frag_row(32'd1, 5'd0));
		dir_rows.push_back(frag_row(32'd1, 5'd1));
		dir_rows.push_back(frag_row(32'd2, 5'd0));
		dir_rows.push_back(frag_row(32'd2, 5'd1));
		dir_rows.push_back(frag_row(32'd3, 5'd1));
		dir_rows.push_back(frag_row(32'd3, 5'd0));
		dir_rows.push_back(known_row(32'h0, 5'd0, efa_pkg::ST_EXPIRED, 1'b0, 32'h0));
		dir_rows.push_back(frag_row(32'd4, 5'd1));
		dir_rows.push_back(frag_row(32'd4, 5'd0));
		dir_rows.push_back(reg_row(efa_pkg::REG_SOURCE_ENABLE, 32'h0));
		dir_rows.push_back(known_row(32'd5, 5'd0, efa_pkg::ST_DISABLED, 1'b0, 32'h0));
		dir_rows.push_back(known_row(32'hFFFF_FFFF, 5'd31, efa_pkg::ST_DISABLED, 1'b0, 32'h0));
		dir_rows.push_back(reg_row(efa_pkg::REG_SOURCE_ENABLE, 32'h1));
		dir_rows.push_back(reg_row(efa_pkg::REG_READY_LIMIT, 32'd0));
		dir_rows.push_back(frag_row(32'd6, 5'd0));
		dir_rows.push_back(frag_row(32'hFFFF_FFFF, 5'd0));

		for (i = 0; i < dir_rows.size(); i++) begin
			row = dir_rows[i];
			if (row.kind == ROW_REG) begin
				write_reg(row.sel[efa_pkg::CFG_IDX_W-1:0], row.value);
			end else begin
				drive_fragment(row.value, row.sel);
				got = assemble_fragment(row.value, row.sel);
				if (row.typed)
					pending_results.push_back(row.want);
				else
					pending_results.push_back(got);
				total_items++;
			end
		end

		// Most requests follow a stream of triggers just ahead of the release point,
		// so events complete, release in order, overtake each other and force skips.
		stream_pos = '0;
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					mask = efa_pkg::MASK_RESET;
					limit = efa_pkg::LIMIT_RESET;
					window = 2;
					n_items = 80;
				end
				1: begin
					mask = 32'h8000_0001;
					limit = 8'd1;
					window = 7;
					n_items = 100;
				end
				2: begin
					mask = (32'h1 << $urandom_range(0, 31)) | (32'h1 << $urandom_range(0, 31))
						| (32'h1 << $urandom_range(0, 31));
					limit = 8'd255;
					window = 7;
					n_items = 140;
				end
				3: begin
					mask = 32'h8000_0000;
					limit = efa_pkg::LIMIT_W'($urandom_range(2, 20));
					window = 5;
					n_items = 100;
				end
				4: begin
					mask = $urandom() | (32'h1 << $urandom_range(0, 31));
					limit = 8'd3;
					window = 2;
					n_items = 80;
				end
				default: begin
					mask = (32'h1 << $urandom_range(0, 31)) | (32'h1 << $urandom_range(0, 31))
						| (32'h1 << $urandom_range(0, 31));
					limit = 8'd2;
					window = 7;
					n_items = 150;
				end
			endcase
			write_reg(efa_pkg::REG_SOURCE_ENABLE, mask);
			write_reg(efa_pkg::REG_READY_LIMIT, efa_pkg::CFG_DAT_W'(limit));
			for (i = 0; i < n_items; i++) begin
				if (due_trigger > stream_pos && due_trigger - stream_pos < 32'h1000_0000)
					stream_pos = due_trigger;
				n = 0;
				while (n < 64 && (tbl_trigger[stream_pos[efa_pkg::IDX_W-1:0]] > stream_pos
						|| (tbl_trigger[stream_pos[efa_pkg::IDX_W-1:0]] == stream_pos
						&& slot_done(stream_pos[efa_pkg::IDX_W-1:0])))) begin
					stream_pos = stream_pos + 1'b1;
					n++;
				end
				r = $urandom_range(0, 99);
				trg = stream_pos + $urandom_range(0, window);
				do src = efa_pkg::SRC_W'($urandom_range(0, efa_pkg::SOURCES - 1));
				while (!mask[src]);
				if (r >= 95) begin
					trg = $urandom();
					src = efa_pkg::SRC_W'($urandom_range(0, 31));
				end else if (r >= 90) begin
					if (stream_pos >= 300)
						trg = stream_pos - $urandom_range(1, 300);
					else
						trg = $urandom_range(0, stream_pos);
				end else if (r >= 84) begin
					trg = trg + efa_pkg::SLOTS;
				end else if (r >= 78) begin
					src = efa_pkg::SRC_W'($urandom_range(0, 31));
				end
				drive_fragment(trg, src);
				pending_results.push_back(assemble_fragment(trg, src));
				total_items++;
			end
		end
		frag_ch.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d fragments over %0d register writes; results: %0d accepted,",
			total_items, cfg_writes, n_by_status[efa_pkg::ST_ACCEPTED]);
		$display("%0d completed, %0d duplicate, %0d expired, %0d disabled",
			n_by_status[efa_pkg::ST_COMPLETED], n_by_status[efa_pkg::ST_DUPLICATE],
			n_by_status[efa_pkg::ST_EXPIRED], n_by_status[efa_pkg::ST_DISABLED]);
		$display("Partial events overwritten: %0d, forced skips: %0d, released in order: %0d",
			n_missed, n_skips, n_released);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
